// ----- design/cdq_pkg.sv -----
// Shared constants, action codes and cell control type for the circular deque.
`default_nettype none

package cdq_pkg;

  // Width of the capacity register and of the stored values.
  localparam int unsigned CapW = 4;
  localparam int unsigned ValW = 32;
  localparam int unsigned ActW = 3;

  // Default maximum capacity, and the largest capacity the 4-bit register can name.
  localparam int unsigned MaxCapacity = 15;
  localparam int unsigned CapHwMax    = 15;

  // Action codes carried on the input channel.
  localparam logic [ActW-1:0] ActInsFront = 3'd0;
  localparam logic [ActW-1:0] ActInsRear  = 3'd1;
  localparam logic [ActW-1:0] ActDelFront = 3'd2;
  localparam logic [ActW-1:0] ActDelRear  = 3'd3;
  localparam logic [ActW-1:0] ActQuery    = 3'd4;

  // Sent to all cells. At most one shift, push or pop; clear can come too and wins.
  typedef struct packed {
    logic clear;
    logic shift_up;
    logic shift_down;
    logic push_rear;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/cdq_cell.sv -----
// One storage cell of the deque chain: a value, an occupancy bit and neighbour hand-off.
`default_nettype none

module cdq_cell (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire cdq_pkg::cell_ctrl_t               ctrl_i,
  input  wire signed [cdq_pkg::ValW-1:0]         ins_value_i,
  input  wire signed [cdq_pkg::ValW-1:0]         left_data_i,
  input  wire                                    left_occ_i,
  input  wire signed [cdq_pkg::ValW-1:0]         right_data_i,
  input  wire                                    right_occ_i,
  output logic signed [cdq_pkg::ValW-1:0]        data_o,
  output logic                                   occ_o,
  output logic                                   rear_o
);

  logic signed [cdq_pkg::ValW-1:0] data_q, data_d;
  logic                            occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctrl_i.shift_up) begin
      // Everything moves one place away from the front.
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (ctrl_i.shift_down) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (ctrl_i.push_rear && left_occ_i && !occ_q) begin
      // Only the first free cell takes the new rear value.
      data_d = ins_value_i;
      occ_d  = 1'b1;
    end else if (ctrl_i.pop_rear && occ_q && !right_occ_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign rear_o = occ_q & ~right_occ_i;

endmodule

`default_nettype wire

// ----- design/circular_deque_top.sv -----
// Top level of the circular deque: cell chain, action decode and result register.
//
//  Channel | Direction | Handshake                  | Beat carries
//  in      | in        | in_valid_i / in_stall_o    | action, value
//  out     | out       | out_valid_o / out_stall_i  | ok, front/rear value, empty, full
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | capacity
//
// An accepted beat updates the cell chain at once and sets a pending flag; the result
// is then loaded into the output register once the output side is not stalled.
// A new beat is accepted in the cycle the previous result is loaded, giving one
// item per cycle while the output side keeps up; the result register sets it.
// Reset empties every cell and sets capacity to the largest the chain holds.
// A capacity write also empties the deque and is taken only with no result pending.
`default_nettype none

module circular_deque_top #(
  parameter int unsigned MAX_CAPACITY = cdq_pkg::MaxCapacity
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire [cdq_pkg::ActW-1:0]              in_action_i,
  input  wire signed [cdq_pkg::ValW-1:0]       in_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 out_ok_o,
  output logic signed [cdq_pkg::ValW-1:0]      out_front_value_o,
  output logic signed [cdq_pkg::ValW-1:0]      out_rear_value_o,
  output logic                                 out_is_empty_o,
  output logic                                 out_is_full_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [cdq_pkg::CapW-1:0]              cfg_capacity_i
);

  // The capacity register is four bits wide, so no more cells than that can be used.
  localparam int unsigned NumCells =
      (MAX_CAPACITY > cdq_pkg::CapHwMax) ? cdq_pkg::CapHwMax : MAX_CAPACITY;
  localparam logic [cdq_pkg::CapW-1:0] CapReset = cdq_pkg::CapW'(NumCells);

  logic [cdq_pkg::CapW-1:0] cap_q, cap_d;
  logic                     pend_q, pend_d;
  logic                     ok_q;
  logic                     out_valid_q, out_valid_d;
  logic                     in_acc, cfg_we, out_load;
  logic                     ok_now, empty, full;

  cdq_pkg::cell_ctrl_t             ctrl;
  logic signed [cdq_pkg::ValW-1:0] cell_data  [NumCells];
  logic signed [cdq_pkg::ValW-1:0] left_data  [NumCells];
  logic signed [cdq_pkg::ValW-1:0] right_data [NumCells];
  logic [NumCells-1:0]             cell_occ, left_occ, right_occ, is_rear, lim;
  logic signed [cdq_pkg::ValW-1:0] rear_sel;

  // Handshakes.
  assign out_load    = pend_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o  = pend_q & out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = ~pend_q;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Capacity register with clamping to the chain length.
  always_comb begin
    cap_d = cap_q;
    if (cfg_we) begin
      if (32'(cfg_capacity_i) > 32'(NumCells)) begin
        cap_d = CapReset;
      end else begin
        cap_d = cfg_capacity_i;
      end
    end
  end

  // Neighbour wiring and the per-cell capacity limit marks.
  for (genvar i = 0; i < NumCells; i++) begin : g_cells
    if (i == 0) begin : g_first
      assign left_data[i] = in_value_i;
      assign left_occ[i]  = 1'b1;
    end else begin : g_mid
      assign left_data[i] = cell_data[i-1];
      assign left_occ[i]  = cell_occ[i-1];
    end
    if (i == NumCells - 1) begin : g_last
      assign right_data[i] = '0;
      assign right_occ[i]  = 1'b0;
    end else begin : g_inner
      assign right_data[i] = cell_data[i+1];
      assign right_occ[i]  = cell_occ[i+1];
    end
    assign lim[i] = (cap_q == cdq_pkg::CapW'(i + 1));

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .ins_value_i  (in_value_i),
      .left_data_i  (left_data[i]),
      .left_occ_i   (left_occ[i]),
      .right_data_i (right_data[i]),
      .right_occ_i  (right_occ[i]),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .rear_o       (is_rear[i])
    );
  end

  // A capacity of zero leaves the deque both empty and full.
  assign empty = ~cell_occ[0];
  assign full  = (cap_q == '0) | (|(cell_occ & lim));

  always_comb begin
    if (in_action_i inside {cdq_pkg::ActInsFront, cdq_pkg::ActInsRear}) begin
      ok_now = ~full;
    end else if (in_action_i inside {cdq_pkg::ActDelFront, cdq_pkg::ActDelRear}) begin
      ok_now = ~empty;
    end else begin
      ok_now = 1'b1;
    end
  end

  always_comb begin
    ctrl       = '0;
    ctrl.clear = cfg_we;
    if (in_acc && ok_now) begin
      case (in_action_i)
        cdq_pkg::ActInsFront: ctrl.shift_up   = 1'b1;
        cdq_pkg::ActInsRear:  ctrl.push_rear  = 1'b1;
        cdq_pkg::ActDelFront: ctrl.shift_down = 1'b1;
        cdq_pkg::ActDelRear:  ctrl.pop_rear   = 1'b1;
        default:              ctrl            = ctrl;
      endcase
    end
  end

  // At most one cell is marked as the rear, so an OR of masked values selects it.
  always_comb begin
    rear_sel = '0;
    for (int i = 0; i < NumCells; i++) begin
      rear_sel = rear_sel | (cell_data[i] & {cdq_pkg::ValW{is_rear[i]}});
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (out_load) begin
      pend_d = 1'b0;
    end
    if (in_acc) begin
      pend_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q <= ok_now;
    end
    if (out_load) begin
      out_ok_o          <= ok_q;
      out_front_value_o <= empty ? -32'sd1 : cell_data[0];
      out_rear_value_o  <= empty ? -32'sd1 : rear_sel;
      out_is_empty_o    <= empty;
      out_is_full_o     <= full;
    end
  end

  assign out_valid_o = out_valid_q;

  // Occupied cells always form an unbroken run from the front.
  a_occ_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_occ & ~left_occ) == '0)
    else $error("deque occupancy has a gap");

  // There is exactly one rear cell when the deque holds anything, none otherwise.
  a_rear_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(is_rear) && ((is_rear == '0) == empty))
    else $error("rear marker inconsistent with occupancy");

  // A refused action leaves the cell occupancy untouched.
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !ok_now && !cfg_we |=> $stable(cell_occ))
    else $error("refused action changed the deque");

  // The deque never holds more values than the configured capacity.
  a_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_occ) <= 32'(cap_q))
    else $error("deque holds more than its capacity");

endmodule

`default_nettype wire

// ----- test/circular_deque_top_tb.sv -----
// Self-checking testbench for the circular deque: a directed table, then random phases.
module circular_deque_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingSlots  = cdq_pkg::MaxCapacity + 1;
  localparam int unsigned NumPhases  = 13;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned QuietLimit = 2000;

  localparam logic [cdq_pkg::ValW-1:0] ValNone = 32'hFFFF_FFFF;
  localparam logic [cdq_pkg::ValW-1:0] ValMax  = 32'h7FFF_FFFF;
  localparam logic [cdq_pkg::ValW-1:0] ValMin  = 32'h8000_0000;

  typedef struct packed {
    logic                            ok;
    logic signed [cdq_pkg::ValW-1:0] front_value;
    logic signed [cdq_pkg::ValW-1:0] rear_value;
    logic                            is_empty;
    logic                            is_full;
  } deque_result_t;

  typedef struct {
    bit                       do_cfg;
    logic [cdq_pkg::CapW-1:0] cap;
    logic [cdq_pkg::ActW-1:0] act;
    logic [cdq_pkg::ValW-1:0] val;
    bit                       typed;
    deque_result_t            res;
  } dir_row_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic [cdq_pkg::ActW-1:0]        in_action_i    = cdq_pkg::ActQuery;
  logic signed [cdq_pkg::ValW-1:0] in_value_i     = '0;
  logic                            out_stall_i    = 1'b0;
  logic                            cfg_valid_i    = 1'b0;
  logic [cdq_pkg::CapW-1:0]        cfg_capacity_i = '0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  logic                            out_ok_o;
  logic signed [cdq_pkg::ValW-1:0] out_front_value_o;
  logic signed [cdq_pkg::ValW-1:0] out_rear_value_o;
  logic                            out_is_empty_o;
  logic                            out_is_full_o;
  logic                            cfg_ready_o;

  // Shadow copy of the deque: ring storage, indices and the capacity setting.
  logic [cdq_pkg::ValW-1:0] ring_mem [RingSlots];
  logic [cdq_pkg::CapW-1:0] head_idx = '0;
  logic [cdq_pkg::CapW-1:0] tail_idx = '0;
  logic [cdq_pkg::CapW-1:0] ring_cap = cdq_pkg::MaxCapacity;

  deque_result_t pending_results [$];
  dir_row_t      dir_rows [$];
  int unsigned   mismatches  = 0;
  int unsigned   quiet_count = 0;
  int unsigned   stall_left  = 0;
  bit            idle_off    = 1'b0;

  always #5 clk_i = ~clk_i;

  circular_deque_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_action_i       (in_action_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_ok_o          (out_ok_o),
    .out_front_value_o (out_front_value_o),
    .out_rear_value_o  (out_rear_value_o),
    .out_is_empty_o    (out_is_empty_o),
    .out_is_full_o     (out_is_full_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_capacity_i    (cfg_capacity_i)
  );

  function automatic logic [cdq_pkg::CapW-1:0] ring_next(input logic [cdq_pkg::CapW-1:0] i);
    return (i == ring_cap) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [cdq_pkg::CapW-1:0] ring_prev(input logic [cdq_pkg::CapW-1:0] i);
    return (i == '0) ? ring_cap : i - 1'b1;
  endfunction

  // Applies one action to the shadow deque and returns the result it should report.
  function automatic deque_result_t apply_action(input logic [cdq_pkg::ActW-1:0] act,
                                                 input logic [cdq_pkg::ValW-1:0] val);
    deque_result_t res;
    logic          full_now;
    logic          empty_now;
    full_now  = (ring_next(tail_idx) == head_idx);
    empty_now = (head_idx == tail_idx);
    res.ok    = 1'b1;
    case (act)
      cdq_pkg::ActInsFront: begin
        if (full_now) begin
          res.ok = 1'b0;
        end else begin
          head_idx           = ring_prev(head_idx);
          ring_mem[head_idx] = val;
        end
      end
      cdq_pkg::ActInsRear: begin
        if (full_now) begin
          res.ok = 1'b0;
        end else begin
          ring_mem[tail_idx] = val;
          tail_idx           = ring_next(tail_idx);
        end
      end
      cdq_pkg::ActDelFront: begin
        if (empty_now) begin
          res.ok = 1'b0;
        end else begin
          head_idx = ring_next(head_idx);
        end
      end
      cdq_pkg::ActDelRear: begin
        if (empty_now) begin
          res.ok = 1'b0;
        end else begin
          tail_idx = ring_prev(tail_idx);
        end
      end
      default: begin
      end
    endcase
    res.is_empty    = (head_idx == tail_idx);
    res.is_full     = (ring_next(tail_idx) == head_idx);
    res.front_value = res.is_empty ? ValNone : ring_mem[head_idx];
    res.rear_value  = res.is_empty ? ValNone : ring_mem[ring_prev(tail_idx)];
    return res;
  endfunction

  function automatic dir_row_t mk_row(input bit do_cfg, input logic [cdq_pkg::CapW-1:0] cap,
                                      input logic [cdq_pkg::ActW-1:0] act,
                                      input logic [cdq_pkg::ValW-1:0] val,
                                      input bit typed, input logic ok,
                                      input logic [cdq_pkg::ValW-1:0] fv,
                                      input logic [cdq_pkg::ValW-1:0] rv,
                                      input logic e, input logic f);
    dir_row_t row;
    row.do_cfg          = do_cfg;
    row.cap             = cap;
    row.act             = act;
    row.val             = val;
    row.typed           = typed;
    row.res.ok          = ok;
    row.res.front_value = fv;
    row.res.rear_value  = rv;
    row.res.is_empty    = e;
    row.res.is_full     = f;
    return row;
  endfunction

  // Holds the beat until it is taken, then records what it should produce.
  // Valid is left high so that a following beat can go out back to back.
  task automatic send_item(input logic [cdq_pkg::ActW-1:0] act,
                           input logic [cdq_pkg::ValW-1:0] val,
                           input bit typed, input deque_result_t typed_res);
    deque_result_t pred;
    in_valid_i  <= 1'b1;
    in_action_i <= act;
    in_value_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_action(act, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic maybe_pause();
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // The capacity is only changed once every outstanding result has drained.
  task automatic write_capacity(input logic [cdq_pkg::CapW-1:0] cap);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ring_cap = (cap > cdq_pkg::MaxCapacity) ? cdq_pkg::CapW'(cdq_pkg::MaxCapacity) : cap;
    head_idx = '0;
    tail_idx = '0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || idle_off) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, 9);
    end
  end

  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok_o !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, out_ok_o);
          mismatches++;
        end
        if (out_front_value_o !== want.front_value) begin
          $error("front_value: expected %0d, actual %0d", want.front_value, out_front_value_o);
          mismatches++;
        end
        if (out_rear_value_o !== want.rear_value) begin
          $error("rear_value: expected %0d, actual %0d", want.rear_value, out_rear_value_o);
          mismatches++;
        end
        if (out_is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, out_is_empty_o);
          mismatches++;
        end
        if (out_is_full_o !== want.is_full) begin
          $error("is_full: expected %0d, actual %0d", want.is_full, out_is_full_o);
          mismatches++;
        end
      end
    end
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    logic [cdq_pkg::ActW-1:0] act;
    logic [cdq_pkg::ValW-1:0] val;
    logic [cdq_pkg::CapW-1:0] cap;
    int unsigned              ins_pct;
    int unsigned              r;

    // Empty and fill from both ends at full capacity, then the smallest rings.
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActQuery, ValMax, 1, 1, ValNone, ValNone, 1, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelFront, ValMin, 1, 0, ValNone, ValNone, 1, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelRear, '0, 1, 0, ValNone, ValNone, 1, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsFront, ValMax, 1, 1, ValMax, ValMax, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsRear, ValMin, 1, 1, ValMax, ValMin, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActQuery + 3'd1, '0, 1, 1, ValMax, ValMin, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActQuery + 3'd2, ValNone, 1, 1, ValMax, ValMin,
                              0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActQuery + 3'd3, ValMin, 1, 1, ValMax, ValMin,
                              0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelRear, '0, 1, 1, ValMax, ValMax, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelFront, '0, 1, 1, ValNone, ValNone, 1, 0));
    dir_rows.push_back(mk_row(1, 1, cdq_pkg::ActInsRear, '0, 1, 1, '0, '0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsFront, 32'd1, 1, 0, '0, '0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsRear, 32'd2, 1, 0, '0, '0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelFront, '0, 1, 1, ValNone, ValNone, 1, 0));
    // A single-slot ring is empty and full at once, so everything but a query is refused.
    dir_rows.push_back(mk_row(1, 0, cdq_pkg::ActQuery, '0, 1, 1, ValNone, ValNone, 1, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsFront, 32'd5, 1, 0, ValNone, ValNone, 1, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsRear, 32'd5, 1, 0, ValNone, ValNone, 1, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelFront, '0, 1, 0, ValNone, ValNone, 1, 1));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelRear, '0, 1, 0, ValNone, ValNone, 1, 1));
    dir_rows.push_back(mk_row(1, 2, cdq_pkg::ActInsFront, ValNone, 0, 0, '0, '0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsFront, 32'h5555_5555, 0, 0, '0, '0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActInsRear, 32'hAAAA_AAAA, 0, 0, '0, '0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelRear, '0, 0, 0, '0, '0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActDelRear, '0, 0, 0, '0, '0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, cdq_pkg::ActQuery, '0, 0, 0, '0, '0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) begin
        write_capacity(dir_rows[i].cap);
      end
      maybe_pause();
      send_item(dir_rows[i].act, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          cap = cdq_pkg::CapW'(cdq_pkg::CapHwMax);
        end
        1: begin
          cap = 4'd1;
        end
        2: begin
          cap = 4'd0;
        end
        default: begin
          cap = ($urandom_range(0, 3) == 0) ? cdq_pkg::CapW'(cdq_pkg::CapHwMax)
                                            : cdq_pkg::CapW'($urandom_range(0, 15));
        end
      endcase
      write_capacity(cap);
      // The final phase, and now and then another, runs with neither side idling.
      idle_off = (phase == NumPhases - 1) || ($urandom_range(0, 4) == 0);
      ins_pct  = 50;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // Swing between filling and draining so both the full and the empty ends are hit.
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: begin
              ins_pct = 80;
            end
            1: begin
              ins_pct = 20;
            end
            default: begin
              ins_pct = 50;
            end
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
          act = cdq_pkg::ActQuery + cdq_pkg::ActW'($urandom_range(0, 3));
        end else if (r < 6 + ins_pct) begin
          act = $urandom_range(0, 1) ? cdq_pkg::ActInsRear : cdq_pkg::ActInsFront;
        end else begin
          act = $urandom_range(0, 1) ? cdq_pkg::ActDelRear : cdq_pkg::ActDelFront;
        end
        case ($urandom_range(0, 15))
          0: begin
            val = ValMax;
          end
          1: begin
            val = ValMin;
          end
          2: begin
            val = ValNone;
          end
          default: begin
            val = $urandom;
          end
        endcase
        maybe_pause();
        send_item(act, val, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
